@@ rtl/core/ckvs_pkg.sv @@
// Shared types, character codes and helper functions of the key/value scanner.
package ckvs_pkg;

  // Sizes of the key and the collected value.
  localparam int KeyMax   = 8;
  localparam int ValueMax = 64;

  // Character codes that the scanner reacts to.
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChCr    = 8'h0D;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgKeyText    = 2'd0,
    CfgKeyLength  = 2'd1,
    CfgValueLimit = 2'd2
  } cfg_idx_e;

  // Result kinds.
  localparam logic KindValue   = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Scan phases.
  typedef enum logic [2:0] {
    PhLine  = 3'd0,
    PhSkip  = 3'd1,
    PhKey   = 3'd2,
    PhTail  = 3'd3,
    PhGap   = 3'd4,
    PhValue = 3'd5,
    PhDone  = 3'd6
  } scan_phase_e;

  // Hex number parse phases.
  typedef enum logic [1:0] {
    NpStart  = 2'd0,
    NpZero   = 2'd1,
    NpDigits = 2'd2,
    NpStop   = 2'd3
  } parse_phase_e;

  // Results caused by one input beat, handed from the scanner to the output buffer.
  typedef struct packed {
    logic        has_val;
    logic [7:0]  val_byte;
    logic        has_sum;
    logic        found;
    logic [6:0]  length;
    logic        form;
    logic [63:0] size;
    logic [63:0] offset;
  } ckvs_res_t;

  // Parse step result.
  typedef struct packed {
    parse_phase_e ph;
    logic [63:0]  acc;
  } parse_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == ChSp) || ((b >= ChTab) && (b <= ChCr));
  endfunction

  // Returns {digit valid, digit value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    if ((b >= ChZero) && (b <= ChNine)) begin
      t = b - ChZero;
      return {1'b1, t[3:0]};
    end
    if ((b >= ChLowA) && (b <= ChLowF)) begin
      t = b - ChLowA + 8'd10;
      return {1'b1, t[3:0]};
    end
    if ((b >= ChUpA) && (b <= ChUpF)) begin
      t = b - ChUpA + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // One byte of hex number parsing with an optional 0x prefix.
  function automatic parse_t parse_step(input parse_phase_e ph, input logic [63:0] acc,
                                        input logic [7:0] b);
    parse_t     r;
    logic [4:0] d;
    d     = hex_digit(b);
    r.ph  = ph;
    r.acc = acc;
    if (ph == NpStop) begin
      r.ph = NpStop;
    end else if ((ph == NpZero) && ((b == ChLowX) || (b == ChUpX))) begin
      r.ph = NpDigits;
    end else if (!d[4]) begin
      r.ph = NpStop;
    end else begin
      r.acc = {acc[59:0], 4'h0} + {60'd0, d[3:0]};
      r.ph  = ((ph == NpStart) && (b == ChZero)) ? NpZero : NpDigits;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ckvs_scan.sv @@
// Scan state, configuration registers and per-byte next-state logic.
module ckvs_scan import ckvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        fire_i,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  output ckvs_res_t   res_o
);

  // Configuration registers.
  logic [63:0] key_text_q;
  logic [3:0]  key_length_q;
  logic [6:0]  value_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_text_q    <= 64'd0;
      key_length_q  <= 4'd1;
      value_limit_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgKeyText:    key_text_q    <= cfg_data_i;
        CfgKeyLength:  key_length_q  <= cfg_data_i[3:0];
        CfgValueLimit: value_limit_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Scan state.
  scan_phase_e  phase_q, phase_d;
  logic [3:0]   key_pos_q, key_pos_d;
  logic [6:0]   count_q, count_d;
  logic [6:0]   at_pos_q, at_pos_d;
  logic         form_ok_q, form_ok_d;
  logic [63:0]  size_q, size_d;
  parse_phase_e size_ph_q, size_ph_d;
  logic [63:0]  offs_q, offs_d;
  parse_phase_e offs_ph_q, offs_ph_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhLine;
      key_pos_q <= 4'd0;
      count_q   <= 7'd0;
      at_pos_q  <= 7'd0;
      form_ok_q <= 1'b1;
      size_q    <= 64'd0;
      size_ph_q <= NpStart;
      offs_q    <= 64'd0;
      offs_ph_q <= NpStart;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      key_pos_q <= key_pos_d;
      count_q   <= count_d;
      at_pos_q  <= at_pos_d;
      form_ok_q <= form_ok_d;
      size_q    <= size_d;
      size_ph_q <= size_ph_d;
      offs_q    <= offs_d;
      offs_ph_q <= offs_ph_d;
    end
  end

  // Effective key length and value limit after clamping.
  logic [3:0] klen;
  logic [6:0] vlim;
  assign klen = (key_length_q > 4'(KeyMax)) ? 4'(KeyMax) : key_length_q;
  assign vlim = (value_limit_q == 7'd0) ? 7'd1 :
                (value_limit_q > 7'(ValueMax)) ? 7'(ValueMax) : value_limit_q;

  // Next state and results for the byte in the input register.
  always_comb begin
    logic [7:0]  b;
    logic        do_key, do_adv, do_gap, do_val, key_hit;
    logic [3:0]  pos, pos_inc;
    logic [7:0]  kc;
    logic [4:0]  hd;
    logic [6:0]  cnt_inc;
    parse_t      ps_size, ps_offs;
    scan_phase_e adv_next;

    b        = text_byte_i;
    do_key   = 1'b0;
    do_adv   = 1'b0;
    do_gap   = 1'b0;
    do_val   = 1'b0;
    pos      = key_pos_q;
    adv_next = PhTail;
    kc       = key_text_q[{pos[2:0], 3'b000} +: 8];
    key_hit  = 1'b0;
    hd       = hex_digit(b);
    cnt_inc  = count_q + 7'd1;
    pos_inc  = 4'd0;
    ps_size  = parse_step(size_ph_q, size_q, b);
    ps_offs  = parse_step(offs_ph_q, offs_q, b);

    phase_d   = phase_q;
    key_pos_d = key_pos_q;
    count_d   = count_q;
    at_pos_d  = at_pos_q;
    form_ok_d = form_ok_q;
    size_d    = size_q;
    size_ph_d = size_ph_q;
    offs_d    = offs_q;
    offs_ph_d = offs_ph_q;
    res_o     = '0;

    case (phase_q)
      PhLine: begin
        if (is_space(b)) begin
          phase_d = PhLine;
        end else if (b == ChHash) begin
          phase_d = PhSkip;
        end else begin
          key_pos_d = 4'd0;
          pos       = 4'd0;
          if (klen == 4'd0) do_gap = 1'b1;
          else              do_key = 1'b1;
        end
      end
      PhSkip: begin
        if (b == ChNl) phase_d = PhLine;
      end
      PhKey:   do_key = 1'b1;
      PhTail:  do_adv = 1'b1;
      PhGap:   do_gap = 1'b1;
      PhValue: do_val = 1'b1;
      default: ;
    endcase

    // Key compare against the selected key character.
    kc = key_text_q[{pos[2:0], 3'b000} +: 8];
    if (do_key) begin
      key_hit = (b == kc);
      if (!key_hit) begin
        phase_d   = (b == ChNl) ? PhLine : PhSkip;
        key_pos_d = 4'd0;
      end else begin
        do_adv   = 1'b1;
        adv_next = (kc == 8'd0) ? PhTail : PhKey;
      end
    end

    // Step to the next key position.
    pos_inc = pos + 4'd1;
    if (do_adv) begin
      key_pos_d = pos_inc;
      phase_d   = (pos_inc >= klen) ? PhGap : adv_next;
    end

    // Gap between key and value.
    if (do_gap) begin
      if ((b == ChSp) || (b == ChTab) || (b == ChEq)) phase_d = PhGap;
      else do_val = 1'b1;
    end

    // Value byte collection, form check and both hex parsers.
    if (do_val) begin
      if (b == ChNl) begin
        phase_d = PhDone;
      end else begin
        res_o.has_val  = 1'b1;
        res_o.val_byte = b;
        if (form_ok_q) begin
          if (b == ChAt) begin
            at_pos_d = count_q;
          end else if (!is_space(b) && (b != ChLowX) && (b != ChUpX) && !hd[4]) begin
            form_ok_d = 1'b0;
            at_pos_d  = 7'd0;
          end
        end
        size_d    = ps_size.acc;
        size_ph_d = ps_size.ph;
        if (b == ChAt) begin
          offs_d    = 64'd0;
          offs_ph_d = NpStart;
        end else begin
          offs_d    = ps_offs.acc;
          offs_ph_d = ps_offs.ph;
        end
        count_d = cnt_inc;
        phase_d = (cnt_inc >= vlim) ? PhDone : PhValue;
      end
    end

    // End of text: summary, then back to the reset state.
    if (last_byte_i) begin
      res_o.has_sum = 1'b1;
      res_o.found   = (count_d != 7'd0);
      res_o.length  = count_d;
      res_o.form    = form_ok_d && (at_pos_d != 7'd0) && (count_d != 7'd0);
      res_o.size    = res_o.form ? size_d : 64'd0;
      res_o.offset  = res_o.form ? offs_d : 64'd0;
      phase_d   = PhLine;
      key_pos_d = 4'd0;
      count_d   = 7'd0;
      at_pos_d  = 7'd0;
      form_ok_d = 1'b1;
      size_d    = 64'd0;
      size_ph_d = NpStart;
      offs_d    = 64'd0;
      offs_ph_d = NpStart;
    end
  end

  // Counters stay within their ranges.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 7'(ValueMax))
    else $error("value count beyond maximum");
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_pos_q <= 4'(KeyMax))
    else $error("key position beyond maximum");
  a_at_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (at_pos_q <= count_q) && (form_ok_q || (at_pos_q == 7'd0)))
    else $error("at position inconsistent with count");

endmodule

@@ rtl/core/ckvs_out.sv @@
// Output buffer holding the value beat and the summary beat of one input beat.
module ckvs_out import ckvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  ckvs_res_t   res_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  value_byte_o,
  output logic        found_o,
  output logic [6:0]  value_length_o,
  output logic        offset_form_o,
  output logic [63:0] image_size_o,
  output logic [63:0] image_offset_o,
  output logic        run_end_o
);

  logic      val_pend_q, val_pend_d;
  logic      sum_pend_q, sum_pend_d;
  ckvs_res_t res_q;
  logic      accept;

  assign accept      = out_valid_o && !out_stall_i;
  assign out_valid_o = val_pend_q || sum_pend_q;
  assign free_o      = !out_valid_o || (accept && !(val_pend_q && sum_pend_q));

  // Pending flags: a load refills, an accepted beat drops the front entry.
  always_comb begin
    val_pend_d = val_pend_q;
    sum_pend_d = sum_pend_q;
    if (load_i) begin
      val_pend_d = res_i.has_val;
      sum_pend_d = res_i.has_sum;
    end else if (accept) begin
      if (val_pend_q) val_pend_d = 1'b0;
      else            sum_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_pend_q <= 1'b0;
      sum_pend_q <= 1'b0;
    end else begin
      val_pend_q <= val_pend_d;
      sum_pend_q <= sum_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  // The value beat goes first, the summary after it.
  assign item_kind_o    = val_pend_q ? KindValue : KindSummary;
  assign value_byte_o   = val_pend_q ? res_q.val_byte : 8'd0;
  assign found_o        = val_pend_q ? 1'b0 : res_q.found;
  assign value_length_o = val_pend_q ? 7'd0 : res_q.length;
  assign offset_form_o  = val_pend_q ? 1'b0 : res_q.form;
  assign image_size_o   = val_pend_q ? 64'd0 : res_q.size;
  assign image_offset_o = val_pend_q ? 64'd0 : res_q.offset;
  assign run_end_o      = val_pend_q ? !sum_pend_q : 1'b1;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("output buffer overwritten");
  a_sum_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_kind_o == KindValue) && !run_end_o)
      |=> (out_valid_o && (item_kind_o == KindSummary)))
    else $error("summary beat did not follow its value beat");
  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (item_kind_o == KindSummary) && !found_o)
      |-> ((value_length_o == 7'd0) && !offset_form_o))
    else $error("summary without value reports a length or form");

endmodule

@@ rtl/core/config_text_key_value_scanner_unit.sv @@
// Top level of the config text key/value scanner.
// Path: a text beat is registered in the input register, then scanned; its value
// beat is offered from the output buffer once its scan results are loaded there.
// Throughput: one text beat per cycle while the output buffer has room; a final beat
// with a value byte fills the output buffer with both a value beat and a summary beat.
// Reset: asynchronous, active low; clears the scan state and sets key_text 0,
// key_length 1, value_limit 64. A summary beat also returns the scan to reset.
module config_text_key_value_scanner_unit import ckvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  value_byte_o,
  output logic        found_o,
  output logic [6:0]  value_length_o,
  output logic        offset_form_o,
  output logic [63:0] image_size_o,
  output logic [63:0] image_offset_o,
  output logic        run_end_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       in_accept, s1_adv, out_free;
  ckvs_res_t  res;

  // Input register: it moves on once its results fit the output buffer.
  assign s1_adv     = s1_valid_q && (!(res.has_val || res.has_sum) || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= text_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  ckvs_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (s1_adv),
    .text_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .res_o       (res)
  );

  ckvs_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (s1_adv && (res.has_val || res.has_sum)),
    .res_i          (res),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_kind_o    (item_kind_o),
    .value_byte_o   (value_byte_o),
    .found_o        (found_o),
    .value_length_o (value_length_o),
    .offset_form_o  (offset_form_o),
    .image_size_o   (image_size_o),
    .image_offset_o (image_offset_o),
    .run_end_o      (run_end_o)
  );

endmodule

@@ tb/ckvs_result_checker.sv @@
// Checker for the key/value scanner: predicts result beats from accepted text beats and compares.
module ckvs_result_checker import ckvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        item_kind_i,
  input  logic [7:0]  value_byte_i,
  input  logic        found_i,
  input  logic [6:0]  value_length_i,
  input  logic        offset_form_i,
  input  logic [63:0] image_size_i,
  input  logic [63:0] image_offset_i,
  input  logic        run_end_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          value_beats_o,
  output int          summary_beats_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result beat.
  typedef struct packed {
    logic        kind;
    logic [7:0]  vbyte;
    logic        found;
    logic [6:0]  len;
    logic        form;
    logic [63:0] size;
    logic [63:0] offset;
    logic        run_end;
  } scan_result_t;

  // Progress of one hex number.
  typedef struct packed {
    parse_phase_e ph;
    logic [63:0]  acc;
  } hex_state_t;

  // Register copies.
  logic [63:0] key_chars;
  logic [3:0]  key_len_reg;
  logic [6:0]  value_limit_reg;

  // Scan state.
  scan_phase_e phase;
  logic [3:0]  key_pos;
  logic [6:0]  val_count;
  logic [6:0]  at_pos;
  logic        form_ok;
  hex_state_t  size_st;
  hex_state_t  off_st;
  logic        got_value;
  logic [7:0]  value_char;

  scan_result_t scan_results_q[$];
  int fails;
  int value_beats;
  int summary_beats;

  function automatic logic blank_char(input logic [7:0] b);
    return (b == ChSp) || ((b >= ChTab) && (b <= ChCr));
  endfunction

  function automatic int hex_nibble(input logic [7:0] b);
    if ((b >= ChZero) && (b <= ChNine)) return int'(b - ChZero);
    if ((b >= ChLowA) && (b <= ChLowF)) return int'(b - ChLowA) + 10;
    if ((b >= ChUpA) && (b <= ChUpF)) return int'(b - ChUpA) + 10;
    return -1;
  endfunction

  // Hex accumulation with an optional 0x prefix; stops for good at a non-hex byte.
  function automatic hex_state_t hex_feed(input hex_state_t s, input logic [7:0] b);
    int d;
    hex_state_t r;
    d = hex_nibble(b);
    r = s;
    if (s.ph == NpStop) begin
      r.ph = NpStop;
    end else if ((s.ph == NpZero) && ((b == ChLowX) || (b == ChUpX))) begin
      r.ph = NpDigits;
    end else if (d < 0) begin
      r.ph = NpStop;
    end else begin
      r.acc = {s.acc[59:0], d[3:0]};
      r.ph  = ((s.ph == NpStart) && (b == ChZero)) ? NpZero : NpDigits;
    end
    return r;
  endfunction

  function automatic logic [3:0] compare_len();
    return (key_len_reg > 4'(KeyMax)) ? 4'(KeyMax) : key_len_reg;
  endfunction

  function automatic logic [6:0] value_cap();
    if (value_limit_reg == 7'd0) return 7'd1;
    return (value_limit_reg > 7'(ValueMax)) ? 7'(ValueMax) : value_limit_reg;
  endfunction

  task clear_scan();
    phase      = PhLine;
    key_pos    = '0;
    val_count  = '0;
    at_pos     = '0;
    form_ok    = 1'b1;
    size_st.ph = NpStart;
    size_st.acc = '0;
    off_st.ph  = NpStart;
    off_st.acc = '0;
  endtask

  // A value byte updates the form check and both hex numbers; a newline ends the value.
  task take_value(input logic [7:0] b);
    if (b == ChNl) begin
      phase = PhDone;
      return;
    end
    got_value  = 1'b1;
    value_char = b;
    if (form_ok) begin
      if (b == ChAt) begin
        at_pos = val_count;
      end else if (!blank_char(b) && (b != ChLowX) && (b != ChUpX) && (hex_nibble(b) < 0)) begin
        form_ok = 1'b0;
        at_pos  = '0;
      end
    end
    size_st = hex_feed(size_st, b);
    if (b == ChAt) begin
      off_st.ph  = NpStart;
      off_st.acc = '0;
    end else begin
      off_st = hex_feed(off_st, b);
    end
    val_count = val_count + 7'd1;
    phase = (val_count >= value_cap()) ? PhDone : PhValue;
  endtask

  task take_gap(input logic [7:0] b);
    if ((b == ChSp) || (b == ChTab) || (b == ChEq)) begin
      phase = PhGap;
    end else begin
      take_value(b);
    end
  endtask

  task step_key(input scan_phase_e nxt);
    key_pos = key_pos + 4'd1;
    phase = (key_pos >= compare_len()) ? PhGap : nxt;
  endtask

  // A zero key byte matched by a zero text byte ends the comparison.
  task take_key(input logic [7:0] b);
    logic [7:0] c;
    c = key_chars[{key_pos[2:0], 3'b000} +: 8];
    if (b != c) begin
      phase   = (b == ChNl) ? PhLine : PhSkip;
      key_pos = '0;
    end else begin
      step_key((c == 8'h00) ? PhTail : PhKey);
    end
  endtask

  // Advances the scan by one text beat and queues the result beats it causes.
  task scan_text_byte(input logic [7:0] b, input logic fin);
    scan_result_t vr;
    scan_result_t sr;
    got_value = 1'b0;
    case (phase)
      PhLine: begin
        if (!blank_char(b)) begin
          if (b == ChHash) begin
            phase = PhSkip;
          end else begin
            key_pos = '0;
            if (compare_len() == 4'd0) take_gap(b);
            else take_key(b);
          end
        end
      end
      PhSkip: begin
        if (b == ChNl) phase = PhLine;
      end
      PhKey:   take_key(b);
      PhTail:  step_key(PhTail);
      PhGap:   take_gap(b);
      PhValue: take_value(b);
      default: ;
    endcase
    if (got_value) begin
      vr         = '0;
      vr.kind    = KindValue;
      vr.vbyte   = value_char;
      vr.run_end = !fin;
      scan_results_q.push_back(vr);
    end
    if (fin) begin
      sr       = '0;
      sr.kind  = KindSummary;
      sr.found = (val_count != 7'd0);
      sr.len   = val_count;
      sr.form  = form_ok && (at_pos != 7'd0) && (val_count != 7'd0);
      if (sr.form) begin
        sr.size   = size_st.acc;
        sr.offset = off_st.acc;
      end
      sr.run_end = 1'b1;
      scan_results_q.push_back(sr);
      clear_scan();
    end
  endtask

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    fails++;
    if (fails <= 40) begin
      $display("[%0t] scanner mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  // Compares one accepted result beat with the oldest prediction.
  task check_result();
    scan_result_t want;
    if (scan_results_q.size() == 0) begin
      report_mismatch("beat with no prediction waiting", 64'(item_kind_i), 64'd0);
      return;
    end
    want = scan_results_q.pop_front();
    if (want.kind == KindSummary) summary_beats++;
    else value_beats++;
    if (item_kind_i !== want.kind) report_mismatch("item_kind", 64'(item_kind_i), 64'(want.kind));
    if (value_byte_i !== want.vbyte)
      report_mismatch("value_byte", 64'(value_byte_i), 64'(want.vbyte));
    if (found_i !== want.found) report_mismatch("found", 64'(found_i), 64'(want.found));
    if (value_length_i !== want.len)
      report_mismatch("value_length", 64'(value_length_i), 64'(want.len));
    if (offset_form_i !== want.form)
      report_mismatch("offset_form", 64'(offset_form_i), 64'(want.form));
    if (image_size_i !== want.size) report_mismatch("image_size", image_size_i, want.size);
    if (image_offset_i !== want.offset)
      report_mismatch("image_offset", image_offset_i, want.offset);
    if (run_end_i !== want.run_end)
      report_mismatch("run_end", 64'(run_end_i), 64'(want.run_end));
  endtask

  // Register writes, text beats and result beats, all taken at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_chars       = '0;
      key_len_reg     = 4'd1;
      value_limit_reg = 7'd64;
      clear_scan();
      scan_results_q.delete();
      fails           = 0;
      value_beats     = 0;
      summary_beats   = 0;
      fail_count_o    <= 0;
      pending_o       <= 0;
      value_beats_o   <= 0;
      summary_beats_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgKeyText:    key_chars = cfg_data_i;
          CfgKeyLength:  key_len_reg = cfg_data_i[3:0];
          CfgValueLimit: value_limit_reg = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) scan_text_byte(text_byte_i, last_byte_i);
      if (out_valid_i && !out_stall_i) check_result();
      fail_count_o    <= fails;
      pending_o       <= scan_results_q.size();
      value_beats_o   <= value_beats;
      summary_beats_o <= summary_beats;
    end
  end

endmodule

@@ tb/config_text_key_value_scanner_unit_test.sv @@
// Testbench top of the key/value scanner: clock, reset, text stimulus, receiver stalls and verdict.
module config_text_key_value_scanner_unit_test import ckvs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TextTarget  = 750;
  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 300;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  cfg_idx_e    cfg_index = CfgKeyText;
  logic [63:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic [7:0]  text_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic        item_kind;
  logic [7:0]  value_byte;
  logic        found;
  logic [6:0]  value_length;
  logic        offset_form;
  logic [63:0] image_size;
  logic [63:0] image_offset;
  logic        run_end;

  int fail_count;
  int pending;
  int value_beats;
  int summary_beats;

  // Stimulus bookkeeping.
  logic [7:0]  text_q[$];
  logic [63:0] key_word      = '0;
  int          key_span      = 1;
  int          zero_pos      = 0;
  int          bytes_sent    = 0;
  int          texts_sent    = 0;
  int          settings_used = 0;
  int          cycle_count   = 0;
  logic        sender_calm   = 1'b0;
  logic        long_hold_req = 1'b0;

  always #1 clk = ~clk;

  config_text_key_value_scanner_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .text_byte_i    (text_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .item_kind_o    (item_kind),
    .value_byte_o   (value_byte),
    .found_o        (found),
    .value_length_o (value_length),
    .offset_form_o  (offset_form),
    .image_size_o   (image_size),
    .image_offset_o (image_offset),
    .run_end_o      (run_end)
  );

  ckvs_result_checker result_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .text_byte_i     (text_byte),
    .last_byte_i     (last_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .item_kind_i     (item_kind),
    .value_byte_i    (value_byte),
    .found_i         (found),
    .value_length_i  (value_length),
    .offset_form_i   (offset_form),
    .image_size_i    (image_size),
    .image_offset_i  (image_offset),
    .run_end_i       (run_end),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .value_beats_o   (value_beats),
    .summary_beats_o (summary_beats)
  );

  // Receiver: one long hold-off on request, otherwise short and long stalls between calm stretches.
  int   stall_left = 0;
  int   calm_left  = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;

  always @(posedge clk) begin : receiver
    int r;
    if (long_hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) calm_left = $urandom_range(40, 160);
      else if (r < 30) stall_left = $urandom_range(1, 3);
      else if (r < 33) stall_left = $urandom_range(10, 40);
      out_stall <= 1'b0;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Run timed out after %0d cycles with %0d results outstanding.", cycle_count,
               pending);
      $display("** config_text_key_value_scanner_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Sender gaps: mostly none, some short, a few long; none in a calm text.
  function automatic int pick_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task add_lead();
    repeat ($urandom_range(0, 2)) text_q.push_back(pick_char(" \t\r\013\014\n"));
  endtask

  // Key characters up to a position; after a zero key byte anything goes.
  task add_key(input int upto);
    for (int i = 0; i < upto; i++) begin
      if ((zero_pos >= 0) && (i > zero_pos)) text_q.push_back(8'($urandom_range(0, 255)));
      else text_q.push_back(key_word[8*i +: 8]);
    end
  endtask

  task add_hex();
    int r;
    int n;
    r = $urandom_range(0, 3);
    if (r == 0) push_str("0x");
    else if (r == 1) push_str("0X");
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
    repeat (n) text_q.push_back(pick_char("0123456789abcdefABCDEF"));
  endtask

  // Values: size@offset forms most often, plus broken forms, long runs and junk.
  task add_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      add_hex();
      if ($urandom_range(0, 2) == 0) text_q.push_back(ChSp);
      text_q.push_back(ChAt);
      add_hex();
      if ($urandom_range(0, 3) == 0) begin
        text_q.push_back(ChAt);
        add_hex();
      end
    end else if (r == 4) begin
      text_q.push_back(ChAt);
      add_hex();
    end else if (r == 5) begin
      add_hex();
      text_q.push_back(pick_char("gz:,;G"));
      text_q.push_back(ChAt);
      add_hex();
    end else if (r == 6) begin
      repeat ($urandom_range(60, 72)) text_q.push_back(pick_char("0123456789abcdefABCDEF@"));
    end else if (r == 7) begin
      repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(33, 126)));
    end else if (r == 8) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // One text of a few lines; now and then cut short inside a line.
  task build_text();
    int lines;
    int r;
    int k;
    lines = $urandom_range(1, 4);
    for (int i = 0; i < lines; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        add_lead();
        add_key(key_span);
        repeat ($urandom_range(0, 3)) text_q.push_back(pick_char(" \t="));
        add_value();
        text_q.push_back(ChNl);
        if ($urandom_range(0, 9) < 7) break;
      end else if (r < 60) begin
        add_lead();
        k = (key_span > 1) ? $urandom_range(1, key_span - 1) : 0;
        add_key(k);
        text_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) text_q.push_back(ChNl);
      end else if (r < 70) begin
        add_lead();
        text_q.push_back(ChHash);
        repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(32, 126)));
        text_q.push_back(ChNl);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
        text_q.push_back(ChNl);
      end else begin
        add_lead();
        text_q.push_back(ChNl);
      end
    end
    if (($urandom_range(0, 3) == 0) && (text_q.size() > 1)) begin
      k = $urandom_range(1, text_q.size() - 1);
      while (text_q.size() > k) text_q.delete(text_q.size() - 1);
    end
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Offers one text beat and holds it until accepted.
  task send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    texts_sent++;
    text_q.delete();
  endtask

  task write_reg(input cfg_idx_e idx, input logic [63:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // Writes all three registers; unused upper data bits carry random values.
  task program_regs(input logic [63:0] kt, input logic [3:0] kl, input logic [6:0] vl);
    logic [63:0] d;
    write_reg(CfgKeyText, kt);
    d = {$urandom, $urandom};
    d[3:0] = kl;
    write_reg(CfgKeyLength, d);
    d = {$urandom, $urandom};
    d[6:0] = vl;
    write_reg(CfgValueLimit, d);
    cfg_we <= 1'b0;
    key_word = kt;
    key_span = (kl > 4'd8) ? 8 : int'(kl);
    zero_pos = -1;
    for (int i = 0; i < key_span; i++) begin
      if ((zero_pos < 0) && (kt[8*i +: 8] == 8'h00)) zero_pos = i;
    end
    settings_used++;
  endtask

  // Register setting for one random phase; the first few phases take the extremes.
  task new_setting(input int p);
    int          kl;
    int          vl;
    int          span;
    int          z;
    logic [63:0] kt;
    case (p)
      0: begin kl = 8;  vl = 64;  end
      1: begin kl = 1;  vl = 1;   end
      2: begin kl = 15; vl = 127; end
      3: begin kl = 0;  vl = 0;   end
      default: begin
        kl = $urandom_range(0, 15);
        case ($urandom_range(0, 4))
          0: vl = 1;
          1: vl = 64;
          2: vl = $urandom_range(65, 127);
          default: vl = $urandom_range(2, 63);
        endcase
      end
    endcase
    kt   = {$urandom, $urandom};
    span = (kl > 8) ? 8 : kl;
    for (int i = 0; i < span; i++) begin
      kt[8*i +: 8] = pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_./");
    end
    if ((span > 0) && ($urandom_range(0, 4) == 0)) begin
      z = $urandom_range(0, span - 1);
      kt[8*z +: 8] = 8'h00;
    end
    program_regs(kt, 4'(kl), 7'(vl));
  endtask

  // Lets every predicted result arrive, then the block settle.
  task wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin : stimulus
    int p;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: a zero key byte of length one, so a zero text byte matches.
    text_q.push_back(8'h00);
    push_str(" 1@f");
    send_text();
    // A comment line, then a full-scale byte that misses the key.
    text_q.push_back(ChHash);
    text_q.push_back(ChNl);
    text_q.push_back(8'hFF);
    send_text();
    // The text ends on the key byte itself.
    text_q.push_back(8'h00);
    send_text();
    wait_idle();

    // Key "ab", three value bytes: a newline inside a partial match, then a clipped value.
    program_regs(64'h0000_0000_0000_6261, 4'd2, 7'd3);
    push_str("a\nab=1234");
    send_text();
    // The text ends inside the key.
    push_str("a");
    send_text();
    wait_idle();

    // Zero key length matches at once; a zero value limit behaves as one.
    program_regs({$urandom, $urandom}, 4'd0, 7'd0);
    push_str(" x");
    send_text();
    wait_idle();

    // Random phases under changing register settings.
    p = 0;
    while (bytes_sent < TextTarget) begin
      new_setting(p);
      if (p == 0) begin
        // Long value while the receiver holds off, so the block backs up into its input.
        long_hold_req <= 1'b1;
        sender_calm = 1'b1;
        add_key(key_span);
        text_q.push_back(ChEq);
        repeat (70) text_q.push_back(pick_char("0123456789abcdef"));
        text_q.push_back(ChNl);
        send_text();
      end
      for (int t = 0; t < 4; t++) begin
        sender_calm = ($urandom_range(0, 4) == 0);
        build_text();
        send_text();
      end
      wait_idle();
      p++;
    end

    $display("Sent %0d text bytes in %0d texts over %0d register settings.", bytes_sent,
             texts_sent, settings_used);
    $display("Compared %0d value beats and %0d summary beats against the prediction.",
             value_beats, summary_beats);
    if (fail_count == 0) begin
      $display("** config_text_key_value_scanner_unit: PASSED **");
    end else begin
      $display("** config_text_key_value_scanner_unit: FAILED **");
    end
    $finish;
  end

endmodule
